@@ rtl/fic_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fic_pkg
// Shared types and constants for the float / integer / fixed-point converter.
// ----------------------------------------------------------------------------
package fic_pkg;

	localparam int unsigned WORD_W            = 32;
	localparam int unsigned MANT_W            = 23;
	localparam int unsigned EXP_W             = 8;
	localparam int unsigned EXP_BIAS          = 127;
	localparam int unsigned SCALE_W           = 5;
	localparam int unsigned FRAC_BITS_DEFAULT = 12;
	localparam int unsigned CMD_W             = 3;

	localparam logic [WORD_W-1:0] OVERFLOW_WORD = 32'h8000_0000;

	typedef enum logic [CMD_W-1:0] {
		CMD_INT_TO_FLT  = 3'd0,
		CMD_UINT_TO_FLT = 3'd1,
		CMD_FLT_TO_INT  = 3'd2,
		CMD_FIX_TO_FLT  = 3'd3,
		CMD_FLT_TO_FIX  = 3'd4
	} cmd_t;

endpackage

@@ rtl/fic_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fic_req_if / fic_rsp_if
// Valid/ready channels carrying converter requests and results.
// ----------------------------------------------------------------------------
interface fic_req_if;
	logic        valid;
	logic        ready;
	logic [2:0]  cmd;
	logic [31:0] operand_bits;

	modport source (output valid, output cmd, output operand_bits, input ready);
	modport sink   (input valid, input cmd, input operand_bits, output ready);
endinterface

interface fic_rsp_if;
	logic        valid;
	logic        ready;
	logic [31:0] result_bits;

	modport source (output valid, output result_bits, input ready);
	modport sink   (input valid, input result_bits, output ready);
endinterface

@@ rtl/fic_int_to_float.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fic_int_to_float
// Integer or fixed-point word to single-precision bits, truncating.
// ----------------------------------------------------------------------------
module fic_int_to_float
	import fic_pkg::*;
(
	input  logic [WORD_W-1:0]  operand,
	input  logic               is_signed,
	input  logic [SCALE_W-1:0] scale,
	output logic [WORD_W-1:0]  result
);

	logic              sign;
	logic [WORD_W-1:0] mag;
	logic [WORD_W-1:0] norm;
	logic [4:0]        lz;
	logic [EXP_W-1:0]  expo;

	assign sign = is_signed & operand[WORD_W-1];
	assign mag  = sign ? (~operand + 32'd1) : operand;

	// five-step normalising shift, leading-zero count falls out of it
	always_comb begin
		norm = mag;
		lz   = '0;
		if (norm[31:16] == 16'd0) begin
			lz[4] = 1'b1;
			norm  = {norm[15:0], 16'd0};
		end
		if (norm[31:24] == 8'd0) begin
			lz[3] = 1'b1;
			norm  = {norm[23:0], 8'd0};
		end
		if (norm[31:28] == 4'd0) begin
			lz[2] = 1'b1;
			norm  = {norm[27:0], 4'd0};
		end
		if (norm[31:30] == 2'd0) begin
			lz[1] = 1'b1;
			norm  = {norm[29:0], 2'd0};
		end
		if (norm[31] == 1'b0) begin
			lz[0] = 1'b1;
			norm  = {norm[30:0], 1'b0};
		end
	end

	// biased exponent: bias + 31 - scale - leading zeros
	assign expo = EXP_W'(EXP_BIAS + WORD_W - 1) - {3'd0, scale} - {3'd0, lz};

	always_comb begin
		if (mag == '0) begin
			result = '0;
		end else begin
			result = {sign, expo, norm[WORD_W-2 -: MANT_W]};
		end
	end

endmodule

@@ rtl/fic_float_to_fixed.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fic_float_to_fixed
// Single-precision bits to a two's complement value, truncating toward zero.
// ----------------------------------------------------------------------------
module fic_float_to_fixed
	import fic_pkg::*;
(
	input  logic [WORD_W-1:0]  operand,
	input  logic [SCALE_W-1:0] scale,
	output logic [WORD_W-1:0]  result
);

	logic signed [9:0]  e;
	logic [4:0]         shamt;
	logic [WORD_W-1:0]  sig;
	logic [WORD_W-1:0]  mag;

	// position of the leading one in the output word
	assign e = $signed({2'b00, operand[WORD_W-2 -: EXP_W]}) + $signed({5'd0, scale})
		- $signed(10'(EXP_BIAS));
	assign shamt = 5'd31 - e[4:0];
	assign sig   = {1'b1, operand[MANT_W-1:0], 8'd0};
	assign mag   = sig >> shamt;

	always_comb begin
		priority if (e < 10'sd0) begin
			result = '0;
		end else if (e > 10'sd30) begin
			result = OVERFLOW_WORD;
		end else if (operand[WORD_W-1]) begin
			result = ~mag + 32'd1;
		end else begin
			result = mag;
		end
	end

endmodule

@@ rtl/float_int_fixed_converter.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// float_int_fixed_converter
// Converts 32-bit words between IEEE single bits and integer / fixed point.
// ----------------------------------------------------------------------------
// One beat in, one beat out, selected per beat by cmd: signed int, unsigned
// int or signed fixed point (FRAC_BITS fraction bits) to float, and float to
// int or fixed point. Conversions truncate; floats below one output step and
// denormals give 0, exponents past bit 30 (including inf and NaN) give
// 0x80000000. A new beat is taken every cycle unless a result is held back
// by a low response.ready; each beat passes through an input register and
// a result register, with the normalising shift and the exponent arithmetic
// forming the path between them.
// ----------------------------------------------------------------------------
module float_int_fixed_converter
	import fic_pkg::*;
#(
	parameter int unsigned FRAC_BITS = FRAC_BITS_DEFAULT
) (
	input  logic   clk,
	input  logic   arst_n,
	fic_req_if.sink   request,
	fic_rsp_if.source response
);

	localparam logic [SCALE_W-1:0] FRAC_SCALE = SCALE_W'(FRAC_BITS);

	logic              valid_s1;
	cmd_t              cmd_s1;
	logic [WORD_W-1:0] operand_s1;
	logic              valid_s2;
	logic [WORD_W-1:0] result_s2;

	logic              advance_s2;
	logic              advance_s1;
	logic              i2f_signed;
	logic [SCALE_W-1:0] scale;
	logic [WORD_W-1:0] i2f_result;
	logic [WORD_W-1:0] f2i_result;
	logic [WORD_W-1:0] result;

	assign advance_s2    = !valid_s2 || response.ready;
	assign advance_s1    = !valid_s1 || advance_s2;
	assign request.ready = advance_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance_s1) begin
			valid_s1 <= request.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance_s1 && request.valid) begin
			cmd_s1     <= cmd_t'(request.cmd);
			operand_s1 <= request.operand_bits;
		end
	end

	assign i2f_signed = (cmd_s1 != CMD_UINT_TO_FLT);
	assign scale = (cmd_s1 == CMD_FIX_TO_FLT || cmd_s1 == CMD_FLT_TO_FIX) ? FRAC_SCALE : '0;

	fic_int_to_float u_i2f (
		.operand   (operand_s1),
		.is_signed (i2f_signed),
		.scale     (scale),
		.result    (i2f_result)
	);

	fic_float_to_fixed u_f2i (
		.operand (operand_s1),
		.scale   (scale),
		.result  (f2i_result)
	);

	always_comb begin
		unique case (cmd_s1)
			CMD_INT_TO_FLT, CMD_UINT_TO_FLT, CMD_FIX_TO_FLT: begin
				result = i2f_result;
			end
			CMD_FLT_TO_INT, CMD_FLT_TO_FIX: begin
				result = f2i_result;
			end
			default: begin
				result = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance_s2 && valid_s1) begin
			result_s2 <= result;
		end
	end

	assign response.valid       = valid_s2;
	assign response.result_bits = result_s2;

endmodule
